@@ design/bba_pkg.sv @@
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and constants for the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

   localparam int WORD_W  = 32;   // free-map bits per RAM word
   localparam int BIT_W   = 5;    // bit index inside a word
   localparam int ORD_W   = 5;    // block order
   localparam int SIZE_W  = 13;
   localparam int ADDR_W  = 12;
   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 16;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // controller -> datapath
   typedef struct packed {
      logic load;       // take request, set up first node
      logic clr;        // clearing pass write
      logic rd;         // read word holding current node
      logic take;       // claim the found block in the scanned word
      logic adv;        // scan on to the next word or level
      logic wr_clr;     // clear current node bit
      logic wr_set;     // set current node bit
      logic split;      // step down one split level
      logic fself;      // buddy merged: point at own node
      logic fin;        // no merge: point at own node for final set
      logic fup;        // move up one level
      logic done_ok;    // latch success result
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clr_done;
      logic in_big;     // incoming order above pool order
      logic in_top;     // incoming order equals pool order
      logic hit;        // scanned word holds a free block in range
      logic exhaust;    // scan ran past the top level
      logic bit_set;    // current node bit in read data
      logic split_more; // another split level to go
      logic next_top;   // one level up is the top level
   } sts_type;

endpackage

@@ design/bba_ram.sv @@
// ----------------------------------------------------------------------------
// bba_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module bba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end
endmodule

@@ design/bba_ctrl.sv @@
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer: clearing pass, allocate scan and split, free and merge walk.
// ----------------------------------------------------------------------------
module bba_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic             req_op,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  bba_pkg::sts_type sts,
   output bba_pkg::cmd_type cmd
);
   import bba_pkg::*;

   localparam logic [3:0] S_CLR    = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_ARD    = 4'd2;
   localparam logic [3:0] S_ACHK   = 4'd3;
   localparam logic [3:0] S_SPL    = 4'd4;
   localparam logic [3:0] S_PRD    = 4'd5;
   localparam logic [3:0] S_PWR    = 4'd6;
   localparam logic [3:0] S_FBRD   = 4'd7;
   localparam logic [3:0] S_FBCHK  = 4'd8;
   localparam logic [3:0] S_FSRD   = 4'd9;
   localparam logic [3:0] S_FSWR   = 4'd10;
   localparam logic [3:0] S_FINRD  = 4'd11;
   localparam logic [3:0] S_FINWR  = 4'd12;
   localparam logic [3:0] S_RESP   = 4'd13;

   logic [3:0] state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_RESP);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLR: begin
            cmd.clr = 1'b1;
            if (sts.clr_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               if (sts.in_big)            state_in = S_RESP;
               else if (req_op == OP_ALLOC) state_in = S_ARD;
               else if (sts.in_top)       state_in = S_FINRD;
               else                       state_in = S_FBRD;
            end
         end
         S_ARD: begin
            cmd.rd   = 1'b1;
            state_in = S_ACHK;
         end
         S_ACHK: begin
            if (sts.hit) begin
               cmd.take = 1'b1;
               state_in = S_SPL;
            end else begin
               cmd.adv  = 1'b1;
               state_in = sts.exhaust ? S_RESP : S_ARD;
            end
         end
         S_SPL: begin
            if (sts.split_more) begin
               cmd.split = 1'b1;
               state_in  = S_PRD;
            end else begin
               cmd.done_ok = 1'b1;
               state_in    = S_RESP;
            end
         end
         S_PRD: begin
            cmd.rd   = 1'b1;
            state_in = S_PWR;
         end
         S_PWR: begin
            cmd.wr_set = 1'b1;
            state_in   = S_SPL;
         end
         S_FBRD: begin
            cmd.rd   = 1'b1;
            state_in = S_FBCHK;
         end
         S_FBCHK: begin
            if (sts.bit_set) begin
               cmd.wr_clr = 1'b1;
               cmd.fself  = 1'b1;
               state_in   = S_FSRD;
            end else begin
               cmd.fin  = 1'b1;
               state_in = S_FINRD;
            end
         end
         S_FSRD: begin
            cmd.rd   = 1'b1;
            state_in = S_FSWR;
         end
         S_FSWR: begin
            cmd.wr_clr = 1'b1;
            cmd.fup    = 1'b1;
            state_in   = sts.next_top ? S_FINRD : S_FBRD;
         end
         S_FINRD: begin
            cmd.rd   = 1'b1;
            state_in = S_FINWR;
         end
         S_FINWR: begin
            cmd.wr_set  = 1'b1;
            cmd.done_ok = 1'b1;
            state_in    = S_RESP;
         end
         S_RESP: begin
            if (rsp_tready) state_in = S_IDLE;
         end
         default: state_in = S_CLR;
      endcase
   end
endmodule

@@ design/bba_dpath.sv @@
// ----------------------------------------------------------------------------
// bba_dpath
// Free-map RAM, node and offset arithmetic, scan and result registers.
// ----------------------------------------------------------------------------
module bba_dpath #(
   parameter int POOL_ORDER = 12
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_op,
   input  logic [bba_pkg::SIZE_W-1:0]    req_size,
   input  logic [bba_pkg::ADDR_W-1:0]    block_addr,
   input  bba_pkg::cmd_type              cmd,
   output bba_pkg::sts_type              sts,
   output logic                          ok,
   output logic [bba_pkg::ADDR_W-1:0]    result_addr
);
   import bba_pkg::*;

   localparam int NW    = POOL_ORDER + 7;   // node index, room for scan overrun
   localparam int WORDS = (POOL_ORDER >= 4) ? (2 ** (POOL_ORDER + 1)) / WORD_W : 1;
   localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam logic [ORD_W-1:0] PORD = ORD_W'(POOL_ORDER);

   logic                  op_ff;
   logic [ORD_W-1:0]      ord_ff, lvl_ff, sp_ff;
   logic [POOL_ORDER-1:0] off_ff;
   logic [NW-1:0]         node_ff;
   logic [AW:0]           clr_cnt_ff;
   logic                  ok_ff;
   logic [ADDR_W-1:0]     addr_ff;

   logic [WORD_W-1:0]     rdata, wdata, lo_mask, hi_mask, cand, bitmask;
   logic                  we, re;
   logic [AW-1:0]         waddr, raddr;

   function automatic logic [NW-1:0] base_of(input logic [ORD_W-1:0] l);
      return (NW'(1) << (PORD - l)) - NW'(1);
   endfunction

   function automatic logic [NW-1:0] self_of(input logic [ORD_W-1:0] l,
                                             input logic [POOL_ORDER-1:0] o);
      return base_of(l) + (NW'(o) >> l);
   endfunction

   function automatic logic [NW-1:0] bud_of(input logic [ORD_W-1:0] l,
                                            input logic [POOL_ORDER-1:0] o);
      return base_of(l) + ((NW'(o) >> l) ^ NW'(1));
   endfunction

   // ceil(log2(size)), with sizes 0 and 1 giving order 0
   logic [SIZE_W-1:0] size_m1;
   logic [ORD_W-1:0]  k_in;
   always_comb begin
      size_m1 = req_size - SIZE_W'(1);
      k_in    = '0;
      if (req_size > SIZE_W'(1)) begin
         for (int b = 0; b < SIZE_W; b++) begin
            if (size_m1[b]) k_in = ORD_W'(b + 1);
         end
      end
   end

   // free address cut to the pool and aligned to the block order
   logic [31:0]           baddr_w;
   logic [POOL_ORDER-1:0] foff_in;
   always_comb begin
      baddr_w = 32'(block_addr) & ((32'd1 << POOL_ORDER) - 32'd1);
      foff_in = baddr_w[POOL_ORDER-1:0]
                & ~((POOL_ORDER'(1) << k_in) - POOL_ORDER'(1));
   end

   // scan of one word of the current level
   logic [NW-1:0]    end_node, next_node, found_node;
   logic [BIT_W-1:0] pe;
   always_comb begin
      end_node  = (NW'(1) << (PORD - lvl_ff + ORD_W'(1))) - NW'(2);
      lo_mask   = {WORD_W{1'b1}} << node_ff[BIT_W-1:0];
      hi_mask   = ((node_ff >> BIT_W) == (end_node >> BIT_W))
                  ? ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - end_node[BIT_W-1:0]))
                  : {WORD_W{1'b1}};
      cand      = rdata & lo_mask & hi_mask;
      pe        = '0;
      for (int b = WORD_W - 1; b >= 0; b--) begin
         if (cand[b]) pe = BIT_W'(b);
      end
      found_node = (node_ff & ~NW'(WORD_W - 1)) | NW'(pe);
      next_node  = (node_ff & ~NW'(WORD_W - 1)) + NW'(WORD_W);
      bitmask    = WORD_W'(1) << node_ff[BIT_W-1:0];
   end

   logic [NW-1:0]         found_rel;
   logic [POOL_ORDER-1:0] off_up;
   logic [ORD_W-1:0]      ord_up;
   assign found_rel = found_node - base_of(lvl_ff);
   assign off_up    = off_ff & ~(POOL_ORDER'(1) << ord_ff);
   assign ord_up    = ord_ff + ORD_W'(1);

   assign sts.clr_done   = (clr_cnt_ff == (AW + 1)'(WORDS - 1));
   assign sts.in_big     = (k_in > PORD);
   assign sts.in_top     = (k_in == PORD);
   assign sts.hit        = |cand;
   assign sts.exhaust    = (next_node > end_node) && (lvl_ff == PORD);
   assign sts.bit_set    = |(rdata & bitmask);
   assign sts.split_more = (sp_ff > ord_ff);
   assign sts.next_top   = (ord_up == PORD);

   // RAM port control
   always_comb begin
      re    = cmd.rd;
      raddr = AW'(node_ff >> BIT_W);
      we    = cmd.clr | cmd.take | cmd.wr_clr | cmd.wr_set;
      waddr = cmd.clr ? clr_cnt_ff[AW-1:0] : AW'(node_ff >> BIT_W);
      priority if (cmd.clr) begin
         wdata = (clr_cnt_ff == '0) ? WORD_W'(1) : '0;   // root free after reset
      end else if (cmd.take) begin
         wdata = rdata & ~(WORD_W'(1) << pe);
      end else if (cmd.wr_clr) begin
         wdata = rdata & ~bitmask;
      end else begin
         wdata = rdata | bitmask;
      end
   end

   bba_ram #(.WIDTH(WORD_W), .DEPTH(WORDS)) u_map (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .re    (re),
      .raddr (raddr),
      .rdata (rdata)
   );

   logic [31:0] off_w;
   assign off_w = 32'(off_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clr) begin
         clr_cnt_ff <= clr_cnt_ff + (AW + 1)'(1);
      end else begin
         clr_cnt_ff <= '0;
      end
      if (cmd.load) begin
         op_ff   <= req_op;
         ord_ff  <= k_in;
         lvl_ff  <= k_in;
         ok_ff   <= 1'b0;
         addr_ff <= '0;
         if (req_op == OP_ALLOC) begin
            off_ff  <= '0;
            node_ff <= base_of(k_in);
         end else begin
            off_ff  <= foff_in;
            node_ff <= (k_in == PORD) ? self_of(k_in, foff_in) : bud_of(k_in, foff_in);
         end
      end
      if (cmd.take) begin
         off_ff <= POOL_ORDER'(found_rel << lvl_ff);
         sp_ff  <= lvl_ff;
      end
      if (cmd.adv) begin
         if (next_node > end_node) begin
            lvl_ff  <= lvl_ff + ORD_W'(1);
            node_ff <= base_of(lvl_ff + ORD_W'(1));
         end else begin
            node_ff <= next_node;
         end
      end
      if (cmd.split) begin
         node_ff <= base_of(sp_ff - ORD_W'(1)) + (NW'(off_ff) >> (sp_ff - ORD_W'(1)))
                    + NW'(1);
         sp_ff   <= sp_ff - ORD_W'(1);
      end
      if (cmd.fself || cmd.fin) begin
         node_ff <= self_of(ord_ff, off_ff);
      end
      if (cmd.fup) begin
         off_ff  <= off_up;
         ord_ff  <= ord_up;
         node_ff <= (ord_up == PORD) ? self_of(ord_up, off_up) : bud_of(ord_up, off_up);
      end
      if (cmd.done_ok) begin
         ok_ff   <= 1'b1;
         addr_ff <= (op_ff == OP_FREE) ? '0 : off_w[ADDR_W-1:0];
      end
   end

   assign ok          = ok_ff;
   assign result_addr = addr_ff;
endmodule

@@ design/buddy_block_allocator_top.sv @@
// ----------------------------------------------------------------------------
// buddy_block_allocator_top
// Binary buddy allocator over a pool of 2^POOL_ORDER bytes.
// ----------------------------------------------------------------------------
//  channel | direction | tdata                         | tuser
//  req     | in        | req_size[12:0], block_addr    | op
//  rsp     | out       | result_addr[11:0]             | ok
//
// After reset a clearing pass writes the free map;
// no request beat is taken until it ends.
// Allocate: each free-map word is read, then checked; each split level is read, then written.
// Free: each node is read, then written.
// One item at a time; a result waits in the output register until taken.
// ----------------------------------------------------------------------------
module buddy_block_allocator_top #(
   parameter int POOL_ORDER = 12
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [bba_pkg::REQ_TDATA_W-1:0]  req_tdata,  // req_size, block_addr, zero
   input  logic                             req_tuser,  // op
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [bba_pkg::RSP_TDATA_W-1:0]  rsp_tdata,  // result_addr, zero
   output logic                             rsp_tuser   // ok
);
   import bba_pkg::*;

   cmd_type           cmd;
   sts_type           sts;
   logic [ADDR_W-1:0] result_addr;

   bba_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   bba_dpath #(.POOL_ORDER(POOL_ORDER)) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_op      (req_tuser),
      .req_size    (req_tdata[SIZE_W-1:0]),
      .block_addr  (req_tdata[SIZE_W+ADDR_W-1:SIZE_W]),
      .cmd         (cmd),
      .sts         (sts),
      .ok          (rsp_tuser),
      .result_addr (result_addr)
   );

   assign rsp_tdata = RSP_TDATA_W'(result_addr);
endmodule

@@ test/tb_buddy_block_allocator_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_buddy_block_allocator_top
// Self-checking bench for the buddy block allocator: a scoreboard keeps its
// own copy of the free-map tree, predicts ok and offset for every request
// beat and checks each response beat in order. Directed corners first, then
// random allocate/free traffic with varying back-pressure on both channels.
// ----------------------------------------------------------------------------
module tb_buddy_block_allocator_top;
   import bba_pkg::*;

   localparam int PORDER    = 12;
   localparam int NODES     = (2 << PORDER) - 1;
   localparam int WDOG_MAX  = 20000;
   localparam int N_RANDOM  = 400;
   localparam int WANT_MAX  = 16;
   localparam int HELD_MAX  = 1024;

   typedef struct packed {
      logic              ok;
      logic [ADDR_W-1:0] addr;
   } alloc_result_type;

   class alloc_scoreboard;
      bit               free_tree[NODES];
      alloc_result_type want_buf[WANT_MAX];
      int               want_rd;
      int               want_wr;
      int               want_cnt;
      int               errors;

      function new();
         foreach (free_tree[i]) free_tree[i] = 1'b0;
         free_tree[0] = 1'b1;
         want_rd  = 0;
         want_wr  = 0;
         want_cnt = 0;
         errors   = 0;
      endfunction

      function int pending();
         return want_cnt;
      endfunction

      function int unsigned size_order(int unsigned sz);
         int unsigned k;
         k = 0;
         while (k < 31 && (32'd1 << k) < sz) k++;
         return k;
      endfunction

      function int unsigned node_idx(int unsigned ord, int unsigned off);
         return ((32'd1 << (PORDER - ord)) - 1) + (off >> ord);
      endfunction

      // predict one request beat; the result is also handed back
      function alloc_result_type note(logic op, logic [SIZE_W-1:0] sz,
                                      logic [ADDR_W-1:0] baddr);
         alloc_result_type r;
         int unsigned      k, off, bud;
         bit               found;
         r.ok = 1'b0;
         r.addr = '0;
         k = size_order(sz);
         found = 0;
         if (k <= PORDER) begin
            if (op == OP_ALLOC) begin
               for (int unsigned j = k; j <= PORDER && !found; j++) begin
                  for (int unsigned i = 0; i < (32'd1 << (PORDER - j)) && !found; i++) begin
                     if (free_tree[node_idx(j, i << j)]) begin
                        found = 1;
                        free_tree[node_idx(j, i << j)] = 1'b0;
                        off = i << j;
                        for (int unsigned s = j; s > k; s--)
                           free_tree[node_idx(s - 1, off + (32'd1 << (s - 1)))] = 1'b1;
                        r.ok = 1'b1;
                        r.addr = off[ADDR_W-1:0];
                     end
                  end
               end
            end else begin
               off = baddr & ~((32'd1 << k) - 1);
               while (k < PORDER) begin
                  bud = node_idx(k, off ^ (32'd1 << k));
                  if (!free_tree[bud]) break;
                  free_tree[bud] = 1'b0;
                  free_tree[node_idx(k, off)] = 1'b0;
                  off &= ~(32'd1 << k);
                  k++;
               end
               free_tree[node_idx(k, off)] = 1'b1;
               r.ok = 1'b1;
            end
         end
         if (want_cnt < WANT_MAX) begin
            want_buf[want_wr] = r;
            want_wr = (want_wr + 1) % WANT_MAX;
            want_cnt++;
         end else begin
            $display("%0t: too many outstanding request beats", $time);
            errors++;
         end
         return r;
      endfunction

      function void check(logic ok, logic [ADDR_W-1:0] addr);
         alloc_result_type w;
         if (want_cnt == 0) begin
            $display("%0t: unexpected response beat ok=%0b addr=%h", $time, ok, addr);
            errors++;
            return;
         end
         w = want_buf[want_rd];
         want_rd = (want_rd + 1) % WANT_MAX;
         want_cnt--;
         if (ok !== w.ok) begin
            $display("%0t: ok mismatch expected %0b actual %0b", $time, w.ok, ok);
            errors++;
         end
         if (addr !== w.addr) begin
            $display("%0t: result_addr mismatch expected %h actual %h",
                     $time, w.addr, addr);
            errors++;
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;  // req_size, block_addr, zero
   logic                   req_tuser = 1'b0; // op
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;       // result_addr, zero
   logic                   rsp_tuser;       // ok

   alloc_scoreboard sb = new();
   int tx_idle = 0;
   int rx_idle = 0;
   int wdog = 0;

   typedef struct {
      int unsigned addr;
      int unsigned sz;
   } held_type;
   held_type held_list[HELD_MAX];
   int       held_cnt = 0;

   buddy_block_allocator_top #(.POOL_ORDER(PORDER)) DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rx_idle);
         if (rsp_tvalid && rsp_tready)
            sb.check(rsp_tuser, rsp_tdata[ADDR_W-1:0]);
      end
   end

   // stall watchdog: cycles with no beat on either channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         wdog <= 0;
      end else begin
         wdog <= wdog + 1;
         if (wdog >= WDOG_MAX) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   task automatic send(input logic op, input int unsigned sz, input int unsigned baddr,
                       output alloc_result_type res);
      while ($urandom_range(0, 99) < tx_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {{(REQ_TDATA_W-SIZE_W-ADDR_W){1'b0}}, baddr[ADDR_W-1:0], sz[SIZE_W-1:0]};
      do @(posedge clock); while (!req_tready);
      res = sb.note(op, sz[SIZE_W-1:0], baddr[ADDR_W-1:0]);
   endtask

   task automatic drain();
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic random_item();
      alloc_result_type res;
      int unsigned      r, o, sz, idx;
      held_type         h;
      r = $urandom_range(0, 99);
      if (r >= 45 && r < 85 && held_cnt != 0) begin
         idx = $urandom_range(0, held_cnt - 1);
         h = held_list[idx];
         held_list[idx] = held_list[held_cnt - 1];
         held_cnt--;
         send(OP_FREE, h.sz, h.addr, res);
      end else if (r >= 85 && r < 90) begin
         // stray free: random size and address, may overlap live blocks
         send(OP_FREE, $urandom_range(0, 8191), $urandom_range(0, 4095), res);
      end else if (r >= 90 && r < 95) begin
         send(1'($urandom_range(0, 1)), $urandom_range(4097, 8191),
              $urandom_range(0, 4095), res);
      end else begin
         if ($urandom_range(0, 9) < 8) o = $urandom_range(0, 6);
         else o = $urandom_range(7, 12);
         sz = (o == 0) ? $urandom_range(0, 1) : $urandom_range((1 << (o - 1)) + 1, 1 << o);
         send(OP_ALLOC, sz, $urandom_range(0, 4095), res);
         if (res.ok && held_cnt < HELD_MAX) begin
            held_list[held_cnt] = '{addr: res.addr, sz: sz};
            held_cnt++;
         end
      end
   endtask

   initial begin
      alloc_result_type res;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      tx_idle = 32;
      rx_idle = 68;

      // directed corners
      send(OP_ALLOC, 0, 12'hfff, res);
      send(OP_ALLOC, 1, 0, res);
      send(OP_ALLOC, 4096, 0, res);          // no space left at top order
      send(OP_FREE, 1, 0, res);
      send(OP_FREE, 1, 1, res);              // merges back to the root
      send(OP_ALLOC, 4097, 0, res);          // too large
      send(OP_FREE, 8191, 12'hfff, res);     // too large, no change
      send(OP_ALLOC, 4096, 0, res);
      send(OP_ALLOC, 1, 0, res);             // pool full
      send(OP_FREE, 4096, 12'hfff, res);     // misaligned, aligned down
      send(OP_ALLOC, 3, 0, res);
      send(OP_ALLOC, 5, 0, res);
      send(OP_ALLOC, 2048, 0, res);
      send(OP_FREE, 2048, 12'h800, res);
      send(OP_FREE, 2048, 12'h800, res);     // double free
      send(OP_FREE, 3, 12'h003, res);        // misaligned small free
      send(OP_FREE, 8, 12'h00c, res);
      send(OP_ALLOC, 2, 0, res);
      send(OP_FREE, 4096, 0, res);           // wipe back to the root

      for (int ph = 0; ph < 3; ph++) begin
         if (ph == 1) begin
            tx_idle = 68;
            rx_idle = 32;
         end else if (ph == 2) begin
            tx_idle = 0;
            rx_idle = 0;
         end
         for (int n = 0; n < N_RANDOM / 3 + 1; n++) random_item();
         req_tvalid <= 1'b0;
         drain();
      end

      repeat (50) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

@@ files.f @@
design/bba_pkg.sv
design/bba_ram.sv
design/bba_ctrl.sv
design/bba_dpath.sv
design/buddy_block_allocator_top.sv
test/tb_buddy_block_allocator_top.sv
